/* design/tet_pkg.sv */
// package: types and codes for the timed event timeline
`timescale 1ns / 1ps
package tet_pkg;
	localparam int TIME_W = 31;
	localparam int DATA_W = 64;
	localparam int KIND_W = 3;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_CLEAR  = 3'd2,
		MODE_PLAY   = 3'd3,
		MODE_PAUSE  = 3'd4,
		MODE_STOP   = 3'd5,
		MODE_SKIP   = 3'd6,
		MODE_NOP    = 3'd7
	} mode_t;

	localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CAMERA   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DIALOGUE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MUSIC    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EVENT    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd7;

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [31:0] delta_time;
		logic signed [31:0] event_time;
		logic [2:0]        event_kind;
		logic [63:0]       payload_low;
		logic [63:0]       payload_high;
	} in_item_t;

	typedef struct packed {
		logic              result_type;
		logic [2:0]        fired_kind;
		logic [63:0]       fired_payload_low;
		logic [63:0]       fired_payload_high;
		logic [TIME_W-1:0] fired_time;
		logic              accepted;
		logic              finished;
		logic [TIME_W-1:0] total_duration;
		logic [TIME_W-1:0] now_time;
		logic              playing_flag;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
	} entry_t;

	// per-cell control shared by the row
	typedef struct packed {
		logic              ins;
		logic              shift;
		logic [TIME_W-1:0] t;
	} cell_ctl_t;
endpackage

/* design/tet_cell.sv */
// cell: one table slot, shifts toward the head or, on insert, takes the new entry or its left neighbour
`timescale 1ns / 1ps
module tet_cell (
	input  logic            clk,
	input  tet_pkg::cell_ctl_t ctl,
	input  logic            valid_in,
	input  tet_pkg::entry_t new_entry,
	input  tet_pkg::entry_t left_entry,
	input  logic            left_gt,
	input  tet_pkg::entry_t right_entry,
	output tet_pkg::entry_t entry,
	output logic            gt
);
	import tet_pkg::*;
	entry_t entry_q;
	logic   my_gt;
	assign my_gt = valid_in && (ctl.t < entry_q.t);
	assign gt = my_gt;
	assign entry = entry_q;
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= right_entry;
		end else if (ctl.ins) begin
			if (my_gt || !valid_in) begin
				entry_q <= left_gt ? left_entry : new_entry;
			end
		end
	end
endmodule

/* design/timed_event_timeline.sv */
// top level: sorted row of event cells with tick and skip sequencing
// sequence: an accepted command passes through EXEC, then FIRE or REWIND where needed, then STATUS;
// FIRE shifts each fired event off the head, and stop after firing rotates the row back in REWIND
// a new command is taken only in IDLE, after the status of the last; output stalls hold the sequencer
// reset: arst_n clears count, position, time, play flag and the output stage
`timescale 1ns / 1ps
module timed_event_timeline #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tet_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output tet_pkg::out_item_t out_item
);
	import tet_pkg::*;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_FIRE   = 5'b00100,
		ST_REWIND = 5'b01000,
		ST_STATUS = 5'b10000
	} state_t;

	state_t state_q;
	in_item_t cmd_q;
	logic [CW-1:0] count_q, pos_q, rew_q;
	logic [TIME_W-1:0] now_q, limit_q, total_q;
	logic playing_q, acc_q;
	logic out_valid_q;
	out_item_t out_q;

	entry_t cells [CAPACITY];
	logic   gts   [CAPACITY];
	cell_ctl_t ctl;
	entry_t new_e, empty_e;
	logic out_free, do_fire, do_shift, do_ins, ins_ok;
	logic fire_emit, status_emit, tick_bad, need_rewind;
	logic [32:0] sum;
	entry_t head;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign new_e = '{t: cmd_q.event_time[31] ? '0 : cmd_q.event_time[TIME_W-1:0],
		kind: cmd_q.event_kind, lo: cmd_q.payload_low, hi: cmd_q.payload_high};
	assign empty_e = '0;
	assign head = cells[0];
	assign ins_ok = !playing_q && now_q == '0 && pos_q == '0 && count_q < CW'(CAPACITY);
	assign do_ins = state_q == ST_EXEC && mode_t'(cmd_q.mode) == MODE_INSERT && ins_ok;
	assign do_fire = state_q == ST_FIRE && out_free && pos_q < count_q
		&& head.t <= limit_q;
	assign do_shift = do_fire || state_q == ST_REWIND;
	assign fire_emit = do_fire && head.kind >= KIND_CAMERA && head.kind <= KIND_EVENT;
	assign status_emit = state_q == ST_STATUS && out_free;
	assign ctl = '{ins: do_ins, shift: do_shift, t: new_e.t};
	assign sum = {2'b0, now_q} + {1'b0, cmd_q.delta_time};
	assign tick_bad = !playing_q || cmd_q.delta_time <= 0 || sum[32:31] != 2'b0;
	// fired entries sit at the tail of the rotated row
	assign need_rewind = pos_q != '0 && pos_q != CW'(CAPACITY);

	// the row holds unfired entries from the head; fired entries rotate off the head
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			tet_cell u_cell (
				.clk(clk), .ctl(ctl),
				.valid_in(CW'(g) < (count_q - pos_q)),
				.new_entry(new_e),
				.left_entry(g == 0 ? empty_e : cells[(g == 0) ? 0 : g-1]),
				.left_gt(g == 0 ? 1'b0 : gts[(g == 0) ? 0 : g-1]),
				.right_entry(g == CAPACITY-1 ? cells[0] : cells[(g+1) % CAPACITY]),
				.entry(cells[g]),
				.gt(gts[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_emit || status_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			rew_q <= '0;
			now_q <= '0;
			playing_q <= 1'b0;
			acc_q <= 1'b0;
			total_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_item;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (mode_t'(cmd_q.mode))
						MODE_TICK: begin
							if (tick_bad) begin
								acc_q <= 1'b0;
								state_q <= ST_STATUS;
							end else begin
								acc_q <= 1'b1;
								now_q <= sum[TIME_W-1:0];
								limit_q <= sum[TIME_W-1:0];
								state_q <= ST_FIRE;
							end
						end
						MODE_INSERT: begin
							acc_q <= ins_ok;
							state_q <= ST_STATUS;
							if (ins_ok) begin
								count_q <= count_q + 1'b1;
								if (count_q == '0 || new_e.t >= total_q) total_q <= new_e.t;
							end
						end
						MODE_CLEAR: begin
							// rotate back any fired entries is unneeded: table emptied
							acc_q <= 1'b1;
							state_q <= ST_STATUS;
							count_q <= '0;
							pos_q <= '0;
							now_q <= '0;
							playing_q <= 1'b0;
							total_q <= '0;
						end
						MODE_PLAY: begin
							acc_q <= 1'b1;
							state_q <= ST_STATUS;
							playing_q <= 1'b1;
						end
						MODE_PAUSE: begin
							acc_q <= 1'b1;
							state_q <= ST_STATUS;
							playing_q <= 1'b0;
						end
						MODE_STOP: begin
							acc_q <= 1'b1;
							playing_q <= 1'b0;
							now_q <= '0;
							pos_q <= '0;
							if (need_rewind) begin
								rew_q <= CW'(CAPACITY) - pos_q;
								state_q <= ST_REWIND;
							end else begin
								state_q <= ST_STATUS;
							end
						end
						MODE_SKIP: begin
							acc_q <= 1'b1;
							limit_q <= total_q;
							now_q <= total_q;
							state_q <= ST_FIRE;
						end
						default: begin
							acc_q <= 1'b0;
							state_q <= ST_STATUS;
						end
					endcase
				end
				ST_FIRE: begin
					if (do_fire) begin
						pos_q <= pos_q + 1'b1;
						if (fire_emit) begin
							out_q <= '{result_type: 1'b1, fired_kind: head.kind,
								fired_payload_low: head.lo, fired_payload_high: head.hi,
								fired_time: head.t, default: '0};
						end
					end else if (out_free) begin
						state_q <= ST_STATUS;
					end
				end
				ST_REWIND: begin
					rew_q <= rew_q - 1'b1;
					if (rew_q == CW'(1)) state_q <= ST_STATUS;
				end
				ST_STATUS: begin
					if (status_emit) begin
						out_q <= '{accepted: acc_q, finished: pos_q >= count_q,
							total_duration: total_q, now_time: now_q,
							playing_flag: playing_q, last: 1'b1, default: '0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule
